// ===== rtl/core/hevc_idr_access_unit_detector_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef HEVC_IDR_ACCESS_UNIT_DETECTOR_TOP_ASSERT_SVH
`define HEVC_IDR_ACCESS_UNIT_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HIDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HIDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hidr_pkg.sv =====
package hidr_pkg;

  localparam int DATA_W      = 8;
  localparam int LEN_IN_W    = 24;
  localparam int WIN_W       = 32;
  localparam int WALK_W      = WIN_W + 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [WIN_W-1:0] START_CODE4  = 32'h0000_0001;
  localparam logic [23:0]      START_CODE3  = 24'h00_0001;
  localparam logic [5:0]       NAL_TYPE_MASK = 6'h3f;
  localparam logic [5:0]       NAL_IDR_W_RADL = 6'd19;
  localparam logic [5:0]       NAL_IDR_N_LP   = 6'd20;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic                first;
    logic                last;
    logic [LEN_IN_W-1:0] length;
    logic                sync;
  } item_t;

  typedef struct packed {
    logic valid;
    logic is_idr;
  } res_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_SEG      = 6'b000010,
    PH_HDR_LAST = 6'b000100,
    PH_HDR_WALK = 6'b001000,
    PH_SKIP     = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

endpackage

// ===== rtl/core/hidr_in_reg.sv =====
module hidr_in_reg
  import hidr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  pop,
  output logic                  item_valid,
  output item_t                 item
);

  logic take;

  assign s_axis_tready = !item_valid || pop;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (pop) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data   <= s_axis_tdata[DATA_W-1:0];
      item.length <= s_axis_tdata[DATA_W+LEN_IN_W-1:DATA_W];
      item.sync   <= s_axis_tdata[DATA_W+LEN_IN_W];
      item.first  <= s_axis_tuser;
      item.last   <= s_axis_tlast;
    end
  end

endmodule

// ===== rtl/core/hidr_scan.sv =====
module hidr_scan
  import hidr_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  item_t item,
  input  logic  out_free,
  output logic  pop,
  output res_t  res
);

  localparam int LB   = LENGTH_BITS;
  localparam int SUMW = LB + 2;

  logic [LB-1:0]    byte_position, byte_position_next;
  logic [LB-1:0]    segment_start, segment_start_next;
  logic [LB-1:0]    header_offset, header_offset_next;
  logic [LB-1:0]    length_latched, length_latched_next;
  logic [WIN_W-1:0] byte_window, byte_window_next;
  phase_t           scan_phase, scan_phase_next;
  logic             found_idr, found_idr_next;

  logic [LB-1:0]     e_pos, e_seg, e_hoff, e_len, len_in, avail;
  logic [WIN_W-1:0]  e_win, win;
  phase_t            e_phase;
  logic              e_found;
  logic [2:0]        k;
  logic              k4, at_end;
  logic [WALK_W-1:0] seg_w, len_w, walk_sum;
  logic              do_check, chk_walk;
  logic [DATA_W-1:0] chk_hdr;
  logic [5:0]        nal_type;

  assign pop = item_valid && (!item.last || out_free);
  assign len_in = LB'({8'd0, item.length});

  always_comb begin
    e_pos   = byte_position;
    e_seg   = segment_start;
    e_hoff  = header_offset;
    e_len   = length_latched;
    e_win   = byte_window;
    e_found = found_idr;
    e_phase = scan_phase;
    if (item.first) begin
      e_pos   = '0;
      e_seg   = '0;
      e_hoff  = '0;
      e_len   = len_in;
      e_win   = '0;
      e_found = 1'b0;
      e_phase = (len_in < LB'(2) || !item.sync) ? PH_DONE : PH_SEG;
    end

    win      = {e_win[WIN_W-9:0], item.data};
    avail    = e_len - e_seg;
    k4       = avail >= LB'(4);
    k        = k4 ? 3'd4 : {1'b0, avail[1:0]};
    at_end   = (SUMW'(e_pos) + SUMW'(1)) == (SUMW'(e_seg) + SUMW'(k));
    seg_w    = WALK_W'(e_seg);
    len_w    = WALK_W'(e_len);
    walk_sum = seg_w + WALK_W'(4) + WALK_W'(win);

    byte_position_next  = e_pos;
    segment_start_next  = e_seg;
    header_offset_next  = e_hoff;
    length_latched_next = e_len;
    byte_window_next    = e_win;
    found_idr_next      = e_found;
    scan_phase_next     = e_phase;
    do_check = 1'b0;
    chk_walk = 1'b0;
    chk_hdr  = item.data;

    if (e_phase != PH_IDLE) begin
      if (e_pos < e_len) begin
        byte_window_next = win;
        unique case (e_phase) inside
          PH_SEG: begin
            if (at_end) begin
              if (k4 && win == START_CODE4) begin
                if (seg_w + WALK_W'(4) < len_w) begin
                  header_offset_next = LB'(seg_w + WALK_W'(4));
                  scan_phase_next    = PH_HDR_LAST;
                end else begin
                  scan_phase_next = PH_DONE;
                end
              end else if (k4 && win[WIN_W-1:8] == START_CODE3) begin
                do_check = 1'b1;
                chk_hdr  = win[7:0];
              end else if (k == 3'd3 && win[23:0] == START_CODE3) begin
                scan_phase_next = PH_DONE;
              end else if (k4) begin
                if (win != '0 && walk_sum <= len_w) begin
                  header_offset_next = LB'(seg_w + WALK_W'(4));
                  segment_start_next = LB'(walk_sum);
                  scan_phase_next    = PH_HDR_WALK;
                end else begin
                  do_check = 1'b1;
                  chk_hdr  = win[31:24];
                end
              end else begin
                do_check = 1'b1;
                chk_hdr  = (k == 3'd3) ? win[23:16] : win[15:8];
              end
            end
          end
          PH_SKIP: begin
            if (e_pos == e_seg) begin
              scan_phase_next = (seg_w + WALK_W'(2) > len_w) ? PH_DONE : PH_SEG;
            end
          end
          PH_HDR_LAST, PH_HDR_WALK: begin
            if (e_pos == e_hoff) begin
              do_check = 1'b1;
              chk_walk = (e_phase == PH_HDR_WALK);
            end
          end
          default: begin
          end
        endcase
      end
      if (e_pos != '1) begin
        byte_position_next = e_pos + LB'(1);
      end
    end

    nal_type = chk_hdr[6:1] & NAL_TYPE_MASK;
    if (do_check) begin
      if (nal_type == NAL_IDR_W_RADL || nal_type == NAL_IDR_N_LP) begin
        found_idr_next  = 1'b1;
        scan_phase_next = PH_DONE;
      end else if (!chk_walk || e_seg == e_len) begin
        scan_phase_next = PH_DONE;
      end else begin
        scan_phase_next = PH_SKIP;
      end
    end

    res.valid  = pop && item.last;
    res.is_idr = (e_phase != PH_IDLE) && found_idr_next;
    if (item.last) begin
      scan_phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      segment_start  <= '0;
      header_offset  <= '0;
      length_latched <= '0;
      byte_window    <= '0;
      found_idr      <= 1'b0;
      scan_phase     <= PH_IDLE;
    end else if (pop) begin
      byte_position  <= byte_position_next;
      segment_start  <= segment_start_next;
      header_offset  <= header_offset_next;
      length_latched <= length_latched_next;
      byte_window    <= byte_window_next;
      found_idr      <= found_idr_next;
      scan_phase     <= scan_phase_next;
    end
  end

endmodule

// ===== rtl/core/hidr_out_reg.sv =====
module hidr_out_reg
  import hidr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  res_t                   res,
  output logic                   out_free,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic is_idr;

  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, is_idr};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      is_idr <= res.is_idr;
    end
  end

endmodule

// ===== rtl/core/hevc_idr_access_unit_detector_top.sv =====
// HEVC IDR access-unit detector.
// Slave stream: one buffer byte per transaction. tuser is first_byte, tlast is
// last_byte; on the first byte tdata also carries the buffer length and the
// encoder sync flag. The scan walks length-prefixed NAL segments, stops at a
// start code or unframed header, and flags NAL types 19 and 20.
// Master stream: one transaction per slave transaction with tlast set; tdata
// bit 0 is is_idr.
// Throughput: one byte per cycle while no last byte waits on a pending result;
// the per-byte compare/update sits between the input register and the result register.
// Result path: the last byte is registered in the input register, and its
// result is then registered in the result register that drives the master side.
// Reset: clears the scan state and the valid flags of both register stages; no result pending.
// Stall: a result waiting on m_axis_tready holds; non-last bytes keep flowing,
// and a second last byte waits in the input register, holding s_axis_tready
// low, until the pending result is taken.
module hevc_idr_access_unit_detector_top
  import hidr_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] data_byte, [31:8] buffer_length, [32] sync_flag, [39:33] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] first_byte
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] is_idr, [7:1] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic  pop;
  logic  item_valid;
  item_t item;
  logic  out_free;
  res_t  res;

  hidr_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .pop           (pop),
    .item_valid    (item_valid),
    .item          (item)
  );

  hidr_scan #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .pop        (pop),
    .res        (res)
  );

  hidr_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/hidr_checker.sv =====
`include "hevc_idr_access_unit_detector_top_assert.svh"

module hidr_checker
  import hidr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `HIDR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `HIDR_ASSERT_NOW(a_out_after_rst, $past(rst), !m_axis_tvalid, "result valid right after reset")
  `HIDR_ASSERT_NOW(a_ready_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")
  `HIDR_ASSERT_NOW(a_out_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0, "result padding not zero")

endmodule

bind hevc_idr_access_unit_detector_top hidr_checker u_checker (.*);
